// File: rtl/ccpb_pkg.sv
package ccpb_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_KERNEL_DEF = 31;

  // job fields sized for the largest parameter values
  localparam int COL_W   = 13;
  localparam int SLOT_W  = 6;
  localparam int KW      = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] CFG_HEIGHT = 3'd0;
  localparam logic [2:0] CFG_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_GAIN   = 3'd3;
  localparam logic [2:0] CFG_OFFSET = 3'd4;
  localparam logic [2:0] CFG_KERNEL = 3'd5;

  typedef struct packed {
    logic [11:0]   height;
    logic [13:0]   width_eff;
    logic [11:0]   radius;
    logic [7:0]    gain;
    logic [7:0]    offset;
    logic [KW-1:0] k_eff;
    logic [15:0]   wsum;
  } cfg_t;

  typedef struct packed {
    logic              is_blur;
    logic              last;
    logic [11:0]       row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
  } job_t;

  typedef logic [31:0][15:0] wsum_tbl_t;

  function automatic wsum_tbl_t build_wsum_tbl();
    wsum_tbl_t t;
    int s, m;
    t = '0;
    for (int k = 1; k < 32; k++) begin
      s = 0;
      for (int a = 0; a < k; a++) begin
        for (int b = 0; b < k; b++) begin
          m = a;
          if (b < m) m = b;
          if (k - 1 - a < m) m = k - 1 - a;
          if (k - 1 - b < m) m = k - 1 - b;
          s = s + 1 + m;
        end
      end
      t[k] = 16'(s);
    end
    return t;
  endfunction

  localparam wsum_tbl_t WSUM_TBL = build_wsum_tbl();

endpackage

// File: rtl/circle_contrast_pyramid_blur_core.sv
// channel   direction  transfer when        payload
// in_       input      in_push & !in_full   pix_blue/green/red, frame_start
// out_      output     out_pop & !out_empty row, col, blue/green/red, from_circle, last_of_run
// cfg_      input      cfg_valid & cfg_ready cfg_index, cfg_data
//
// front takes no new pixel until it has stepped through its states
// (write, square, compare, two queue slots); a full job queue holds it in a queue slot
// a blur window reads K*K taps from the line store (one read port), then drains,
// divides (8 steps) and outputs; a contrast result passes multiply, saturate and output
// a pixel waits in_full while a window read of the line store is still open
// rst_n is synchronous; the line store holds no reset state, counters and queues clear
// results stall only on out_pop; the job queue holds up to 4 entries
module circle_contrast_pyramid_blur_core #(
  parameter int MAX_WIDTH  = ccpb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = ccpb_pkg::MAX_KERNEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_pix_blue,
  input  logic [7:0]  in_pix_green,
  input  logic [7:0]  in_pix_red,
  input  logic        in_frame_start,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [11:0] out_row,
  output logic [10:0] out_col,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic        out_from_circle,
  output logic        out_last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int AW = CW + SW;
  localparam int KW = ccpb_pkg::KW;

  logic [11:0] height_r, width_r, radius_r;
  logic [7:0]  gain_r, offset_r;
  logic [4:0]  ksize_r;
  logic [15:0] wsum_r;

  ccpb_pkg::cfg_t cfg;
  logic [KW-1:0]  k_eff;
  logic [13:0]    w_eff;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [23:0]    ram_wdata, ram_rdata;
  logic           q_push, q_full, q_pop, q_empty, blur_done;
  ccpb_pkg::job_t q_in, q_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (ksize_r == '0) begin
      k_eff = KW'(1);
    end else if (7'(ksize_r) > 7'(MAX_KERNEL)) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = KW'(ksize_r);
    end
    if (width_r == '0) begin
      w_eff = 14'd1;
    end else if (14'(width_r) > 14'(MAX_WIDTH)) begin
      w_eff = 14'(MAX_WIDTH);
    end else begin
      w_eff = 14'(width_r);
    end
    cfg.height    = height_r;
    cfg.width_eff = w_eff;
    cfg.radius    = radius_r;
    cfg.gain      = gain_r;
    cfg.offset    = offset_r;
    cfg.k_eff     = k_eff;
    cfg.wsum      = wsum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= 12'd480;
      width_r  <= 12'd640;
      radius_r <= 12'd0;
      gain_r   <= 8'd1;
      offset_r <= 8'd0;
      ksize_r  <= 5'd3;
      wsum_r   <= ccpb_pkg::WSUM_TBL[3];
    end else begin
      wsum_r <= ccpb_pkg::WSUM_TBL[k_eff[4:0]];
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ccpb_pkg::CFG_HEIGHT: height_r <= cfg_data;
          ccpb_pkg::CFG_WIDTH:  width_r  <= cfg_data;
          ccpb_pkg::CFG_RADIUS: radius_r <= cfg_data;
          ccpb_pkg::CFG_GAIN:   gain_r   <= cfg_data[7:0];
          ccpb_pkg::CFG_OFFSET: offset_r <= cfg_data[7:0];
          ccpb_pkg::CFG_KERNEL: ksize_r  <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  ccpb_ram #(
    .WIDTH(24),
    .DEPTH(MAX_KERNEL * (2 ** CW))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ccpb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_pix_blue    (in_pix_blue),
    .in_pix_green   (in_pix_green),
    .in_pix_red     (in_pix_red),
    .in_frame_start (in_frame_start),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .q_push         (q_push),
    .q_job          (q_in),
    .q_full         (q_full),
    .blur_done      (blur_done)
  );

  ccpb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_out),
    .empty    (q_empty)
  );

  ccpb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_job           (q_out),
    .q_pop           (q_pop),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .blur_done       (blur_done),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_blue        (out_blue),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_from_circle (out_from_circle),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: rtl/ccpb_ram.sv
module ccpb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ccpb_queue.sv
module ccpb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ccpb_pkg::job_t    push_job,
  output logic              full,
  input  logic              pop,
  output ccpb_pkg::job_t    pop_job,
  output logic              empty
);

  localparam int PW = $clog2(ccpb_pkg::QUEUE_DEPTH);
  localparam int CNTW = $clog2(ccpb_pkg::QUEUE_DEPTH + 1);

  ccpb_pkg::job_t  slot_r [ccpb_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNTW'(ccpb_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_job;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + PW'(1);
      if (do_pop)  rp_r <= rp_r + PW'(1);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

endmodule

// File: rtl/ccpb_front.sv
module ccpb_front #(
  parameter int MAX_WIDTH  = ccpb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = ccpb_pkg::MAX_KERNEL_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccpb_pkg::cfg_t       cfg,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_pix_blue,
  input  logic [7:0]           in_pix_green,
  input  logic [7:0]           in_pix_red,
  input  logic                 in_frame_start,
  output logic                 ram_we,
  output logic [$clog2(MAX_WIDTH)+((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] ram_waddr,
  output logic [23:0]          ram_wdata,
  output logic                 q_push,
  output ccpb_pkg::job_t       q_job,
  input  logic                 q_full,
  input  logic                 blur_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_CMP  = 3'd2;
  localparam logic [2:0] F_PB   = 3'd3;
  localparam logic [2:0] F_PC   = 3'd4;

  function automatic logic [13:0] absdiff(logic [13:0] x, logic [13:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  logic [2:0]    st_r;
  logic [11:0]   row_r;
  logic [CW-1:0] col_r;
  logic [SW-1:0] slot_r;
  logic          pend_r;

  logic [11:0]   i_r, ar_r;
  logic [CW-1:0] j_r, ac_r;
  logic [SW-1:0] aslot_r;
  logic [23:0]   rgb_r;
  logic          geom_r;
  logic [27:0]   sqai_r, sqaj_r, sqci_r, sqcj_r;
  logic [23:0]   r2_r;
  logic          bnda_r, bndc_r;
  logic          blur_go_r, con_go_r;

  logic          accept;
  logic [11:0]   i_base;
  logic [CW-1:0] j_base, j_eff;
  logic [SW-1:0] s_base;
  logic [13:0]   ch, cw, ch2, cw2;
  logic [13:0]   dai, daj, dci, dcj;
  logic          in_a, in_c;
  logic [6:0]    aslot_t;

  assign in_full = (st_r != F_IDLE) || pend_r;
  assign accept  = in_push && !in_full;

  always_comb begin
    i_base  = in_frame_start ? '0 : row_r;
    j_base  = in_frame_start ? '0 : col_r;
    s_base  = in_frame_start ? '0 : slot_r;
    j_eff   = (14'(j_base) >= cfg.width_eff) ? '0 : j_base;
    aslot_t = 7'(s_base) + 7'(MAX_KERNEL) + 7'd1 - 7'(cfg.k_eff);
    if (aslot_t >= 7'(MAX_KERNEL)) aslot_t = aslot_t - 7'(MAX_KERNEL);
  end

  assign ram_we    = accept;
  assign ram_waddr = {s_base, j_eff};
  assign ram_wdata = {in_pix_red, in_pix_green, in_pix_blue};

  // circle centre and bounds
  always_comb begin
    ch  = 14'(cfg.height[11:1]);
    cw  = 14'(cfg.width_eff[13:1]);
    ch2 = {ch[12:0], 1'b0};
    cw2 = {cw[12:0], 1'b0};
    dai = absdiff(14'(ar_r), ch);
    daj = absdiff(14'(ac_r), cw);
    dci = absdiff(14'(i_r), ch);
    dcj = absdiff(14'(j_r), cw);
    in_a = bnda_r && ((29'(sqai_r) + 29'(sqaj_r)) <= 29'(r2_r));
    in_c = bndc_r && ((29'(sqci_r) + 29'(sqcj_r)) <= 29'(r2_r));
  end

  always_comb begin
    q_push = 1'b0;
    q_job  = '0;
    q_job.row   = i_r;
    q_job.col   = ccpb_pkg::COL_W'(j_r);
    q_job.red   = rgb_r[23:16];
    q_job.green = rgb_r[15:8];
    q_job.blue  = rgb_r[7:0];
    q_job.last  = 1'b1;
    if (st_r == F_PB) begin
      q_push        = blur_go_r;
      q_job.is_blur = 1'b1;
      q_job.row     = ar_r;
      q_job.col     = ccpb_pkg::COL_W'(ac_r);
      q_job.slot    = ccpb_pkg::SLOT_W'(aslot_r);
      q_job.last    = !con_go_r;
    end else if (st_r == F_PC) begin
      q_push = con_go_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_r     <= i_base;
      j_r     <= j_eff;
      rgb_r   <= {in_pix_red, in_pix_green, in_pix_blue};
      geom_r  <= (14'(i_base) + 14'd1 >= 14'(cfg.k_eff)) &&
                 (14'(j_eff) + 14'd1 >= 14'(cfg.k_eff)) &&
                 (i_base < cfg.height);
      ar_r    <= 12'(14'(i_base) + 14'd1 - 14'(cfg.k_eff));
      ac_r    <= CW'(14'(j_eff) + 14'd1 - 14'(cfg.k_eff));
      aslot_r <= SW'(aslot_t);
    end
    if (st_r == F_SQ) begin
      sqai_r <= dai * dai;
      sqaj_r <= daj * daj;
      sqci_r <= dci * dci;
      sqcj_r <= dcj * dcj;
      r2_r   <= cfg.radius * cfg.radius;
      bnda_r <= (14'(ar_r) <= ch2) && (14'(ac_r) <= cw2);
      bndc_r <= (14'(i_r) <= ch2) && (14'(j_r) <= cw2);
    end
    if (st_r == F_CMP) begin
      blur_go_r <= geom_r && !in_a;
      con_go_r  <= in_c;
    end
    if (!rst_n) begin
      st_r   <= F_IDLE;
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (q_push && !q_full && q_job.is_blur) begin
        pend_r <= 1'b1;
      end else if (blur_done) begin
        pend_r <= 1'b0;
      end
      unique case (st_r)
        F_IDLE: begin
          if (accept) begin
            st_r <= F_SQ;
            if (14'(j_eff) + 14'd1 >= cfg.width_eff) begin
              col_r <= '0;
              if (13'(i_base) + 13'd1 >= 13'(cfg.height)) begin
                row_r  <= '0;
                slot_r <= '0;
              end else begin
                row_r  <= i_base + 12'd1;
                slot_r <= (7'(s_base) + 7'd1 == 7'(MAX_KERNEL)) ? '0 : s_base + SW'(1);
              end
            end else begin
              col_r  <= j_eff + CW'(1);
              row_r  <= i_base;
              slot_r <= s_base;
            end
          end
        end
        F_SQ:  st_r <= F_CMP;
        F_CMP: st_r <= F_PB;
        F_PB: begin
          if (!blur_go_r || !q_full) st_r <= F_PC;
        end
        F_PC: begin
          if (!con_go_r || !q_full) st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // line store must not be overwritten while a window is still being read
  a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !accept) else $error("pixel taken during window read");
  a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_full && q_job.is_blur) |=> pend_r)
    else $error("blur job queued without hold");
`endif

endmodule

// File: rtl/ccpb_back.sv
module ccpb_back #(
  parameter int MAX_WIDTH  = ccpb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = ccpb_pkg::MAX_KERNEL_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccpb_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  ccpb_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 ram_re,
  output logic [$clog2(MAX_WIDTH)+((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] ram_raddr,
  input  logic [23:0]          ram_rdata,
  output logic                 blur_done,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [11:0]          out_row,
  output logic [10:0]          out_col,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_green,
  output logic [7:0]           out_red,
  output logic                 out_from_circle,
  output logic                 out_last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KW = ccpb_pkg::KW;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CMUL = 3'd1;
  localparam logic [2:0] B_CSAT = 3'd2;
  localparam logic [2:0] B_BLUR = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0]     st_r;
  ccpb_pkg::job_t job_r;
  logic [KW-1:0]  a_r, b_r;
  logic [SW-1:0]  slot_r;
  logic           iss_r, v1_r, v2_r;
  logic [KW-1:0]  w_d1_r;
  logic [13:0]    prod_r [3];
  logic [23:0]    acc_r [3];
  logic [23:0]    rem_r [3];
  logic [7:0]     q_r [3];
  logic [15:0]    con_r [3];
  logic [2:0]     bit_r;
  logic [15:0]    ws_r;
  logic [7:0]     res_r [3];
  logic           out_vld_r;
  logic [11:0]    o_row_r;
  logic [10:0]    o_col_r;
  logic [7:0]     o_ch_r [3];
  logic           o_circ_r, o_last_r;

  logic [KW-1:0]  km1, ra, cb, wt;
  logic           last_b, last_a;
  logic [23:0]    trial;
  logic [23:0]    rem_nxt [3];
  logic [7:0]     q_nxt [3];
  logic [7:0]     pix [3];
  logic [7:0]     job_ch [3];
  logic [16:0]    sum [3];

  assign q_pop     = (st_r == B_IDLE) && !q_empty;
  assign out_empty = !out_vld_r;

  assign pix[0] = ram_rdata[7:0];
  assign pix[1] = ram_rdata[15:8];
  assign pix[2] = ram_rdata[23:16];
  assign job_ch[0] = job_r.blue;
  assign job_ch[1] = job_r.green;
  assign job_ch[2] = job_r.red;

  // pyramid weight of the current tap
  always_comb begin
    km1    = cfg.k_eff - KW'(1);
    ra     = (a_r <= km1 - a_r) ? a_r : (km1 - a_r);
    cb     = (b_r <= km1 - b_r) ? b_r : (km1 - b_r);
    wt     = KW'(1) + ((ra <= cb) ? ra : cb);
    last_b = (b_r == km1);
    last_a = (a_r == km1);
  end

  assign ram_re    = (st_r == B_BLUR) && iss_r;
  assign ram_raddr = {slot_r, CW'(job_r.col[CW-1:0] + CW'(b_r))};
  assign blur_done = ram_re && last_a && last_b;

  // one restoring step per cycle, eight quotient bits
  always_comb begin
    trial = 24'(ws_r) << bit_r;
    for (int c = 0; c < 3; c++) begin
      rem_nxt[c] = rem_r[c];
      q_nxt[c]   = q_r[c];
      if (rem_r[c] >= trial) begin
        rem_nxt[c] = rem_r[c] - trial;
        q_nxt[c]   = q_r[c] | (8'd1 << bit_r);
      end
      sum[c] = 17'(con_r[c]) + 17'(cfg.offset);
    end
  end

  always_ff @(posedge clk) begin
    w_d1_r <= wt;
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= pix[c] * w_d1_r;
    end
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          job_r  <= q_job;
          a_r    <= '0;
          b_r    <= '0;
          slot_r <= q_job.slot[SW-1:0];
          iss_r  <= 1'b1;
          ws_r   <= (cfg.wsum == '0) ? 16'd1 : cfg.wsum;
          for (int c = 0; c < 3; c++) acc_r[c] <= '0;
        end
      end
      B_CMUL: begin
        for (int c = 0; c < 3; c++) con_r[c] <= job_ch[c] * cfg.gain;
      end
      B_CSAT: begin
        for (int c = 0; c < 3; c++) begin
          res_r[c] <= (sum[c] > 17'd255) ? 8'd255 : sum[c][7:0];
        end
      end
      B_BLUR: begin
        if (iss_r) begin
          if (last_b) begin
            b_r <= '0;
            if (last_a) begin
              iss_r <= 1'b0;
            end else begin
              a_r    <= a_r + KW'(1);
              slot_r <= (7'(slot_r) + 7'd1 == 7'(MAX_KERNEL)) ? '0 : slot_r + SW'(1);
            end
          end else begin
            b_r <= b_r + KW'(1);
          end
        end
        if (v2_r) begin
          for (int c = 0; c < 3; c++) acc_r[c] <= acc_r[c] + 24'(prod_r[c]);
        end
        if (!iss_r && !v1_r && !v2_r) begin
          bit_r <= 3'd7;
          for (int c = 0; c < 3; c++) begin
            rem_r[c] <= acc_r[c];
            q_r[c]   <= '0;
          end
        end
      end
      B_DIV: begin
        bit_r <= bit_r - 3'd1;
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= rem_nxt[c];
          q_r[c]   <= q_nxt[c];
          res_r[c] <= q_nxt[c];
        end
      end
      default: begin
      end
    endcase
    if ((st_r == B_OUT) && (!out_vld_r || out_pop)) begin
      o_row_r  <= job_r.row;
      o_col_r  <= 11'(job_r.col);
      o_circ_r <= !job_r.is_blur;
      o_last_r <= job_r.last;
      for (int c = 0; c < 3; c++) o_ch_r[c] <= res_r[c];
    end
    if (!rst_n) begin
      st_r      <= B_IDLE;
      out_vld_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      v1_r <= ram_re;
      v2_r <= v1_r;
      if ((st_r == B_OUT) && (!out_vld_r || out_pop)) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
      unique case (st_r)
        B_IDLE: begin
          if (!q_empty) st_r <= q_job.is_blur ? B_BLUR : B_CMUL;
        end
        B_CMUL: st_r <= B_CSAT;
        B_CSAT: st_r <= B_OUT;
        B_BLUR: begin
          if (!iss_r && !v1_r && !v2_r) st_r <= B_DIV;
        end
        B_DIV: begin
          if (bit_r == 3'd0) st_r <= B_OUT;
        end
        B_OUT: begin
          if (!out_vld_r || out_pop) st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign out_row         = o_row_r;
  assign out_col         = o_col_r;
  assign out_blue        = o_ch_r[0];
  assign out_green       = o_ch_r[1];
  assign out_red         = o_ch_r[2];
  assign out_from_circle = o_circ_r;
  assign out_last_of_run = o_last_r;

`ifndef ASSERT_OFF
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DIV) |-> (!v1_r && !v2_r && !iss_r))
    else $error("divide started before window sum complete");
  a_ws_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DIV) |-> (ws_r != '0)) else $error("zero divisor");
`endif

endmodule

// File: tb/circle_contrast_pyramid_blur_core_tb.sv
`timescale 1ns / 100ps

module circle_contrast_pyramid_blur_core_tb;

  typedef struct {
    int row;
    int col;
    int blue;
    int green;
    int red;
    int circ;
    int last;
  } pix_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_pix_blue;
  logic [7:0]  in_pix_green;
  logic [7:0]  in_pix_red;
  logic        in_frame_start;
  logic        out_empty;
  logic        out_pop;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        out_from_circle;
  logic        out_last_of_run;

  // predictor state
  int unsigned height, width, radius, gain, offset, ksize, wsum;
  int unsigned row_pos, col_pos;
  logic [23:0] line_rows [31][2048];

  pix_result_t pending_q[$];
  bit failed;
  bit quiet;

  circle_contrast_pyramid_blur_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_pix_blue(in_pix_blue),
    .in_pix_green(in_pix_green), .in_pix_red(in_pix_red), .in_frame_start(in_frame_start),
    .out_empty(out_empty), .out_pop(out_pop), .out_row(out_row), .out_col(out_col),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .out_from_circle(out_from_circle), .out_last_of_run(out_last_of_run)
  );

  always #10 clk = ~clk;

  function automatic int unsigned kernel_eff();
    return (ksize == 0) ? 1 : ((ksize > 31) ? 31 : ksize);
  endfunction

  function automatic int unsigned width_eff();
    return (width == 0) ? 1 : ((width > 2048) ? 2048 : width);
  endfunction

  function automatic int unsigned pyramid_weight(int unsigned a, int unsigned b, int unsigned k);
    int unsigned m;
    m = a;
    if (b < m) m = b;
    if (k - 1 - a < m) m = k - 1 - a;
    if (k - 1 - b < m) m = k - 1 - b;
    return 1 + m;
  endfunction

  function automatic bit in_circle(int unsigned i, int unsigned j);
    longint ch, cw, di, dj;
    ch = height / 2;
    cw = width_eff() / 2;
    if (longint'(i) > 2 * ch || longint'(j) > 2 * cw) return 0;
    di = longint'(i) - ch;
    dj = longint'(j) - cw;
    return di * di + dj * dj <= longint'(radius) * longint'(radius);
  endfunction

  function automatic int unsigned boost(int unsigned v);
    int unsigned s;
    s = v * gain + offset;
    return (s > 255) ? 255 : s;
  endfunction

  // advances the raster position and queues the results this pixel causes
  task automatic predict_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                               input logic fs);
    int unsigned k, w, i, j, ar, ac, wt, ws, sb, sg, sr;
    logic [23:0] px;
    pix_result_t res;
    int n;
    k = kernel_eff();
    w = width_eff();
    n = 0;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    i = row_pos;
    j = col_pos;
    line_rows[i % 31][j] = {r, g, b};
    if (i + 1 >= k && j + 1 >= k && i < height) begin
      ar = i + 1 - k;
      ac = j + 1 - k;
      if (!in_circle(ar, ac)) begin
        sb = 0; sg = 0; sr = 0;
        ws = (wsum == 0) ? 1 : wsum;
        for (int a = 0; a < k; a++) begin
          for (int c = 0; c < k; c++) begin
            px = line_rows[(ar + a) % 31][ac + c];
            wt = pyramid_weight(a, c, k);
            sb += px[7:0] * wt;
            sg += px[15:8] * wt;
            sr += px[23:16] * wt;
          end
        end
        res = '{ar & 12'hfff, ac & 11'h7ff, sb / ws, sg / ws, sr / ws, 0, 0};
        pending_q.push_back(res);
        n++;
      end
    end
    if (in_circle(i, j)) begin
      res = '{i, j, boost(b), boost(g), boost(r), 1, 0};
      pending_q.push_back(res);
      n++;
    end
    if (n > 0) pending_q[pending_q.size() - 1].last = 1;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= height) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    int unsigned k;
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val[11:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ccpb_pkg::CFG_HEIGHT: height = val & 12'hfff;
      ccpb_pkg::CFG_WIDTH:  width = val & 12'hfff;
      ccpb_pkg::CFG_RADIUS: radius = val & 12'hfff;
      ccpb_pkg::CFG_GAIN:   gain = val & 8'hff;
      ccpb_pkg::CFG_OFFSET: offset = val & 8'hff;
      ccpb_pkg::CFG_KERNEL: begin
        ksize = val & 5'h1f;
        k = kernel_eff();
        wsum = 0;
        for (int a = 0; a < k; a++)
          for (int c = 0; c < k; c++) wsum += pyramid_weight(a, c, k);
        wsum &= 16'hffff;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic fs);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 16) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_pix_blue = b;
    in_pix_green = g;
    in_pix_red = r;
    in_frame_start = fs;
    do @(posedge clk); while (in_full);
    predict_pixel(b, g, r, fs);
  endtask

  // results are all in, then give a dropped pixel time to leave the front end
  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic setup(input int unsigned h, input int unsigned w, input int unsigned r,
                       input int unsigned g, input int unsigned o, input int unsigned k);
    drain();
    write_reg(ccpb_pkg::CFG_HEIGHT, h);
    write_reg(ccpb_pkg::CFG_WIDTH, w);
    write_reg(ccpb_pkg::CFG_RADIUS, r);
    write_reg(ccpb_pkg::CFG_GAIN, g);
    write_reg(ccpb_pkg::CFG_OFFSET, o);
    write_reg(ccpb_pkg::CFG_KERNEL, k);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int count, input int noise_pct);
    for (int n = 0; n < count; n++)
      send_pixel(rand_chan(), rand_chan(), rand_chan(),
                 (n == 0) || ($urandom_range(99) < noise_pct));
  endtask

  task automatic test_reset_values();
    // only the centre pixel lands in a zero radius circle, nothing here is blurred yet
    send_frame(20, 0);
  endtask

  task automatic test_contrast_extremes();
    setup(4, 4, 4095, 255, 255, 2);
    for (int n = 0; n < 8; n++)
      send_pixel((n & 1) ? 8'hff : 8'h00, (n & 2) ? 8'hff : 8'h00, 8'h01, n == 0);
    setup(4, 4, 4095, 0, 0, 2);
    for (int n = 0; n < 8; n++) send_pixel(8'hff, 8'h80, 8'h7f, n == 0);
  endtask

  task automatic test_kernel_extremes();
    setup(3, 5, 0, 2, 3, 0);
    send_frame(15, 0);
    setup(31, 31, 0, 1, 0, 31);
    send_frame(961, 0);
  endtask

  task automatic test_size_extremes();
    setup(4095, 4095, 4095, 3, 7, 2);
    send_frame(40, 0);
    setup(2, 2048, 4095, 1, 1, 1);
    send_frame(40, 0);
    setup(3, 0, 1, 5, 0, 2);
    send_frame(10, 0);
    setup(0, 6, 2, 4, 9, 1);
    send_frame(12, 0);
  endtask

  task automatic test_random_frames();
    for (int p = 0; p < 12; p++) begin
      setup($urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(0, 8),
            $urandom_range(255), $urandom_range(255),
            ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4));
      quiet = (p == 4);
      send_frame(30, 2);
      if (p == 7) begin
        // let the block run dry mid-frame, then start the next frame
        @(negedge clk);
        in_push = 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
      end
      send_frame(30, 2);
      quiet = 1'b0;
    end
  endtask

  always @(negedge clk) out_pop = quiet || ($urandom_range(99) >= 16);

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    pix_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_q.size() == 0) begin
        $error("result at row %0d col %0d with none expected", out_row, out_col);
        failed = 1'b1;
      end else begin
        want = pending_q.pop_front();
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("out_blue", want.blue, out_blue);
        check_field("out_green", want.green, out_green);
        check_field("out_red", want.red, out_red);
        check_field("out_from_circle", want.circ, out_from_circle);
        check_field("out_last_of_run", want.last, out_last_of_run);
      end
    end
  end

  initial begin
    #200_000_000;
    $display("circle_contrast_pyramid_blur_core_tb: errors");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ccpb_pkg::CFG_HEIGHT;
    cfg_data = '0;
    in_push = 1'b0;
    in_pix_blue = '0;
    in_pix_green = '0;
    in_pix_red = '0;
    in_frame_start = 1'b0;
    out_pop = 1'b0;
    failed = 1'b0;
    quiet = 1'b0;
    height = 480; width = 640; radius = 0; gain = 1; offset = 0; ksize = 3; wsum = 10;
    row_pos = 0; col_pos = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_contrast_extremes();
    test_size_extremes();
    test_random_frames();
    test_kernel_extremes();
    drain();

    if (failed || pending_q.size() != 0) begin
      $display("circle_contrast_pyramid_blur_core_tb: errors");
    end else begin
      $display("circle_contrast_pyramid_blur_core_tb: clean");
    end
    $finish;
  end

endmodule

// File: circle_contrast_pyramid_blur_core.f
rtl/ccpb_pkg.sv
rtl/ccpb_ram.sv
rtl/ccpb_queue.sv
rtl/ccpb_front.sv
rtl/ccpb_back.sv
rtl/circle_contrast_pyramid_blur_core.sv
tb/circle_contrast_pyramid_blur_core_tb.sv
